>>> sv/sst_pkg.sv
// ============================================================================
// sst_pkg
// Shared types and constants for the Solovay-Strassen prime test block.
// ============================================================================
`default_nettype none

package sst_pkg;

    localparam int NUM_WIDTH   = 31;
    localparam int ROUND_WIDTH = 8;

    typedef logic [NUM_WIDTH-1:0]   t_num;
    typedef logic [ROUND_WIDTH-1:0] t_rounds;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WIT,
        ST_JAC_RED,
        ST_JAC_MOD,
        ST_POW_START,
        ST_POW_STEP,
        ST_MUL,
        ST_VERIFY,
        ST_DONE
    } t_state;

    // Datapath operations, issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_WIT_INIT,
        OP_WIT_STEP,
        OP_JAC_INIT,
        OP_JAC_SHIFT,
        OP_JAC_SWAP,
        OP_MOD_STEP,
        OP_POW_INIT,
        OP_MUL_SQR,
        OP_MUL_ACC,
        OP_MUL_STEP,
        OP_POW_SHIFT,
        OP_NEXT_ROUND
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic n_is_two;
        logic n_composite;   // below 2 or even
        logic rounds_done;
        logic jac_a_zero;
        logic jac_a_even;
        logic mod_done;      // remainder loop finished
        logic exp_zero;
        logic exp_lsb;
        logic mul_done;
        logic pass;          // power equals expected value, symbol nonzero
    } t_status;

endpackage

`default_nettype wire

>>> sv/sst_if.sv
// ============================================================================
// sst_if
// Valid/ready channel carrying one word of payload.
// ============================================================================
`default_nettype none

interface sst_in_if import sst_pkg::*; ();
    logic    valid;
    logic    ready;
    t_num    candidate;
    t_rounds rounds;
    modport source (output valid, output candidate, output rounds, input ready);
    modport sink   (input valid, input candidate, input rounds, output ready);
endinterface

interface sst_out_if;
    logic valid;
    logic ready;
    logic probable_prime;
    modport source (output valid, output probable_prime, input ready);
    modport sink   (input valid, input probable_prime, output ready);
endinterface

`default_nettype wire

>>> sv/sst_datapath.sv
// ============================================================================
// sst_datapath
// Registers and arithmetic: witness generation, bit-serial remainders for the
// Jacobi symbol, and shift-and-add modular multiplication for the power.
// ============================================================================
`default_nettype none

module sst_datapath import sst_pkg::*; (
    input  wire logic    i_clk,
    input  wire t_cmd    i_cmd,
    input  wire t_num    i_candidate,
    input  wire t_rounds i_rounds,
    output t_status      o_status
);

    localparam int CW = $clog2(NUM_WIDTH + 1);

    // One extra bit keeps sums of two residues below the carry.
    typedef logic [NUM_WIDTH:0] t_wide;

    t_num    r_n, r_nm2, r_wit, r_ja, r_jm, r_base, r_acc, r_exp, r_mx, r_my, r_mres;
    t_num    r_rem, r_quo;
    t_rounds r_rounds, r_idx;
    logic    r_sign, r_mul_sqr;
    logic [CW-1:0] r_cnt;

    t_wide w_wit3, w_madd, w_mdbl, w_rem2;
    t_num  w_wit_next, w_mres_next, w_mx_next, w_rem_next, w_want;
    logic  w_flip_shift, w_flip_swap;

    always_comb begin
        // Witness advances by 3 modulo n-2; one subtract suffices while n-2 > 3,
        // otherwise it runs through up to three subtracts in turn.
        w_wit3 = {1'b0, r_wit} + t_wide'(3);
        if (w_wit3 >= {1'b0, r_nm2}) w_wit3 = w_wit3 - {1'b0, r_nm2};
        if (w_wit3 >= {1'b0, r_nm2}) w_wit3 = w_wit3 - {1'b0, r_nm2};
        if (w_wit3 >= {1'b0, r_nm2}) w_wit3 = w_wit3 - {1'b0, r_nm2};
        w_wit_next = w_wit3[NUM_WIDTH-1:0];

        // Modular product step.
        w_madd = {1'b0, r_mres} + {1'b0, r_mx};
        if (w_madd >= {1'b0, r_n}) w_madd = w_madd - {1'b0, r_n};
        w_mres_next = r_my[0] ? w_madd[NUM_WIDTH-1:0] : r_mres;
        w_mdbl = {r_mx, 1'b0};
        if (w_mdbl >= {1'b0, r_n}) w_mdbl = w_mdbl - {1'b0, r_n};
        w_mx_next = w_mdbl[NUM_WIDTH-1:0];

        // Restoring remainder step: a mod m, one bit of a per cycle.
        w_rem2 = {r_rem, r_quo[NUM_WIDTH-1]};
        if (w_rem2 >= {1'b0, r_jm}) w_rem2 = w_rem2 - {1'b0, r_jm};
        w_rem_next = w_rem2[NUM_WIDTH-1:0];

        w_flip_shift = (r_jm[2:0] == 3'd3) || (r_jm[2:0] == 3'd5);
        w_flip_swap  = (r_jm[1:0] == 2'd3) && (r_ja[1:0] == 2'd3);
        w_want = r_sign ? (r_n - t_num'(1)) : t_num'(1);
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_n      <= i_candidate;
                r_nm2    <= i_candidate - t_num'(2);
                r_rounds <= i_rounds;
            end
            OP_WIT_INIT: begin
                r_wit <= '0;
                r_idx <= '0;
            end
            OP_WIT_STEP: r_wit <= w_wit_next;
            OP_JAC_INIT: begin
                // Witness 2 + w is below n, so a mod n is itself.
                r_ja   <= r_wit + t_num'(2);
                r_jm   <= r_n;
                r_sign <= 1'b0;
            end
            OP_JAC_SHIFT: begin
                r_ja <= r_ja >> 1;
                if (w_flip_shift) r_sign <= ~r_sign;
            end
            OP_JAC_SWAP: begin
                // New m is old a; new a = old m mod old a, computed bit-serially.
                r_jm  <= r_ja;
                r_ja  <= r_jm;
                r_quo <= r_jm;
                r_rem <= '0;
                r_cnt <= CW'(NUM_WIDTH);
                if (w_flip_swap) r_sign <= ~r_sign;
            end
            OP_MOD_STEP: begin
                r_rem <= w_rem_next;
                r_quo <= r_quo << 1;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) r_ja <= w_rem_next;
            end
            OP_POW_INIT: begin
                r_base <= r_wit + t_num'(2);
                r_acc  <= t_num'(1);
                r_exp  <= (r_n - t_num'(1)) >> 1;
            end
            OP_MUL_ACC: begin
                r_mx <= r_acc; r_my <= r_base; r_mres <= '0; r_mul_sqr <= 1'b0;
            end
            OP_MUL_SQR: begin
                r_mx <= r_base; r_my <= r_base; r_mres <= '0; r_mul_sqr <= 1'b1;
            end
            OP_MUL_STEP: begin
                r_mres <= w_mres_next;
                r_mx   <= w_mx_next;
                r_my   <= r_my >> 1;
                if (r_my[NUM_WIDTH-1:1] == '0) begin
                    if (r_mul_sqr) r_base <= w_mres_next;
                    else           r_acc  <= w_mres_next;
                end
            end
            OP_POW_SHIFT: r_exp <= r_exp >> 1;
            OP_NEXT_ROUND: begin
                r_idx <= r_idx + ROUND_WIDTH'(1);
                r_wit <= w_wit_next;
            end
            default: ;
        endcase
    end

    // Status back to the controller.
    always_comb begin
        o_status.n_is_two    = (r_n == t_num'(2));
        o_status.n_composite = (r_n < t_num'(2)) || !r_n[0];
        o_status.rounds_done = (r_idx == r_rounds);
        o_status.jac_a_zero  = (r_ja == '0);
        o_status.jac_a_even  = !r_ja[0];
        o_status.mod_done    = (r_cnt == '0);
        o_status.exp_zero    = (r_exp == '0);
        o_status.exp_lsb     = r_exp[0];
        o_status.mul_done    = (r_my == '0);
        o_status.pass        = (r_jm == t_num'(1)) && (r_acc == w_want);
    end

endmodule

`default_nettype wire

>>> sv/sst_ctrl.sv
// ============================================================================
// sst_ctrl
// Sequencer for the prime test: rounds, Jacobi loop, square-and-multiply.
// ============================================================================
`default_nettype none

module sst_ctrl import sst_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output logic         o_result,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;
    logic   r_valid, r_result, r_sqr_next;
    logic   w_set, w_res;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid && !r_valid) n_state = ST_CHECK;
            ST_CHECK: begin
                if (i_status.n_is_two || i_status.n_composite) n_state = ST_DONE;
                else n_state = ST_WIT;
            end
            ST_WIT: n_state = i_status.rounds_done ? ST_DONE : ST_JAC_RED;
            ST_JAC_RED: begin
                if (i_status.jac_a_zero) n_state = ST_POW_START;
                else if (!i_status.jac_a_even) n_state = ST_JAC_MOD;
            end
            ST_JAC_MOD: if (i_status.mod_done) n_state = ST_JAC_RED;
            ST_POW_START: n_state = ST_POW_STEP;
            ST_POW_STEP: n_state = i_status.exp_zero ? ST_VERIFY : ST_MUL;
            ST_MUL: if (i_status.mul_done) n_state = ST_POW_STEP;
            ST_VERIFY: n_state = i_status.pass ? ST_WIT : ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs: datapath command and result capture.
    always_comb begin
        o_cmd.op = OP_NONE;
        w_set = 1'b0;
        w_res = 1'b0;
        case (r_state)
            ST_IDLE: if (i_in_valid && !r_valid) o_cmd.op = OP_LOAD;
            ST_CHECK: begin
                o_cmd.op = OP_WIT_INIT;
                if (i_status.n_is_two) begin
                    w_set = 1'b1; w_res = 1'b1;
                end else if (i_status.n_composite) begin
                    w_set = 1'b1;
                end
            end
            ST_WIT: begin
                if (i_status.rounds_done) begin
                    w_set = 1'b1; w_res = 1'b1;
                end else o_cmd.op = OP_JAC_INIT;
            end
            ST_JAC_RED: begin
                if (i_status.jac_a_zero) o_cmd.op = OP_POW_INIT;
                else if (i_status.jac_a_even) o_cmd.op = OP_JAC_SHIFT;
                else o_cmd.op = OP_JAC_SWAP;
            end
            ST_JAC_MOD: if (!i_status.mod_done) o_cmd.op = OP_MOD_STEP;
            ST_POW_STEP: begin
                if (!i_status.exp_zero) begin
                    if (r_sqr_next) o_cmd.op = OP_MUL_SQR;
                    else if (i_status.exp_lsb) o_cmd.op = OP_MUL_ACC;
                    else o_cmd.op = OP_MUL_SQR;
                end
            end
            ST_MUL: o_cmd.op = i_status.mul_done ?
                               (r_sqr_next ? OP_NONE : OP_POW_SHIFT) : OP_MUL_STEP;
            ST_VERIFY: begin
                if (i_status.pass) o_cmd.op = OP_NEXT_ROUND;
                else w_set = 1'b1;
            end
            default: ;
        endcase
    end

    // The square that follows a product, then the exponent shift after the square.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= 1'b0;
            r_sqr_next <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_POW_STEP && !i_status.exp_zero)
                r_sqr_next <= !r_sqr_next && i_status.exp_lsb;
            if (r_state == ST_POW_START) r_sqr_next <= 1'b0;
            if (w_set) r_valid <= 1'b1;
            else if (r_valid && i_out_ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_set) r_result <= w_res;
    end

    assign o_in_ready  = (r_state == ST_IDLE) && !r_valid;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

>>> sv/solovay_strassen_prime_test.sv
// ============================================================================
// solovay_strassen_prime_test
// Solovay-Strassen probable-prime test over a candidate and a round count.
// ============================================================================
// One word in gives one word out. The value 2, even values and values below
// 2 are settled at the check, with no rounds. Otherwise each round runs a
// Jacobi loop of halvings and remainders; each remainder comes from a
// bit-serial divider, one bit a cycle, with the swap and the return around it.
// A square-and-multiply power follows over the up to 30 bits of (n-1)/2, with
// up to two modular products per exponent bit. Each product is a shift-and-add
// over the bits of its multiplier (up to 31), with a closing step and an issue
// step. The first failing round ends the item. The block works on one item at
// a time; the result word is held in an output register until taken.
`default_nettype none

module solovay_strassen_prime_test import sst_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sst_in_if.sink    i_in,
    sst_out_if.source o_out
);

    t_cmd    w_cmd;
    t_status w_status;

    sst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_result    (o_out.probable_prime),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    sst_datapath u_dp (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_candidate (i_in.candidate),
        .i_rounds    (i_in.rounds),
        .o_status    (w_status)
    );

endmodule

`default_nettype wire

>>> sv/sst_checker.sv
// ============================================================================
// sst_checker
// Port-level checks on the prime test's handshakes.
// ============================================================================
`default_nettype none

module sst_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic o_out_valid,
    input wire logic o_out_ready,
    input wire logic o_probable_prime
);

    // A result word holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_ready |=> o_out_valid && $stable(o_probable_prime))
        else $error("result word changed before it was taken");

    // No new word is taken while a result waits.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !i_in_ready)
        else $error("input accepted while a result is pending");

    // After an accept, the block is busy on the next cycle.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready stayed high after an accept");

endmodule

bind solovay_strassen_prime_test sst_checker u_sst_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .o_out_valid      (o_out.valid),
    .o_out_ready      (o_out.ready),
    .o_probable_prime (o_out.probable_prime)
);

`default_nettype wire

>>> tb/tb_solovay_strassen_prime_test.sv
// ============================================================================
// tb_solovay_strassen_prime_test
// Self-checking bench for the Solovay-Strassen probable-prime test block.
// ============================================================================
// A queue of candidate words is fed to the input channel by a clocked driver.
// Every accepted word gets its verdict computed by a local primality
// predictor, and a clocked monitor compares each output word with the oldest
// pending verdict. Sender and receiver back off at random in several phases.
`default_nettype none

module tb_solovay_strassen_prime_test import sst_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_num    candidate;
        t_rounds rounds;
        bit      drain_first;   // hold this word until every verdict is back
    } t_test_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sst_in_if  in_if ();
    sst_out_if out_if ();

    solovay_strassen_prime_test DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_test_word pending_words[$];
    bit         verdicts_due[$];
    int         words_taken = 0;
    int         mismatches = 0;
    bit         stimulus_done = 1'b0;

    always #10 i_clk = ~i_clk;

    // Modular product by shift-and-add, every partial sum kept below m.
    function automatic longint unsigned mulmod(longint unsigned x, longint unsigned y,
                                               longint unsigned m);
        longint unsigned acc;
        acc = 0;
        while (y != 0) begin
            if (y[0]) begin
                acc += x;
                if (acc >= m) acc -= m;
            end
            x += x;
            if (x >= m) x -= m;
            y >>= 1;
        end
        return acc;
    endfunction

    function automatic longint unsigned powmod(longint unsigned b, longint unsigned e,
                                               longint unsigned m);
        longint unsigned acc;
        acc = 1 % m;
        b = b % m;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, b, m);
            b = mulmod(b, b, m);
            e >>= 1;
        end
        return acc;
    endfunction

    // Jacobi symbol (a/m) for odd m of 3 or more.
    function automatic int jacobi_sym(longint unsigned a, longint unsigned m);
        int              sign;
        longint unsigned t;
        sign = 1;
        a = a % m;
        while (a != 0) begin
            while (!a[0]) begin
                a >>= 1;
                if (m[2:0] == 3'd3 || m[2:0] == 3'd5) sign = -sign;
            end
            t = a;
            a = m;
            m = t;
            if (a[1:0] == 2'd3 && m[1:0] == 2'd3) sign = -sign;
            a = a % m;
        end
        return (m == 1) ? sign : 0;
    endfunction

    function automatic bit is_probable_prime(t_num cand, t_rounds rounds);
        longint unsigned n;
        longint unsigned b;
        longint unsigned want;
        int              j;
        n = cand;
        if (n == 2) return 1'b1;
        if (n < 2 || !n[0]) return 1'b0;
        for (int i = 0; i < int'(rounds); i++) begin
            b = 2 + (longint'(i) * 3) % (n - 2);
            j = jacobi_sym(b, n);
            if (j == 0) return 1'b0;
            want = (j > 0) ? 1 : n - 1;
            if (powmod(b, (n - 1) >> 1, n) != want) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Idle rates follow the phase of the run: sender light, then receiver light.
    function automatic int sender_idle_pct();
        if (words_taken < 40) return 36;
        if (words_taken < 80) return 62;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (words_taken < 40) return 62;
        if (words_taken < 80) return 36;
        return 0;
    endfunction

    // Driver: log each accepted word, then present the next one or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.candidate <= '0;
            in_if.rounds    <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                verdicts_due.push_back(is_probable_prime(in_if.candidate, in_if.rounds));
                words_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_words.size() == 0 ||
                    (pending_words[0].drain_first &&
                     (verdicts_due.size() != 0 || (in_if.valid && in_if.ready))) ||
                    $urandom_range(99) < sender_idle_pct()) begin
                    in_if.valid <= 1'b0;
                end else begin
                    t_test_word w;
                    w = pending_words.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.candidate <= w.candidate;
                    in_if.rounds    <= w.rounds;
                end
            end
        end
    end

    // Receiver backpressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 1'b0;
        else          out_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
    end

    // Monitor: each output word against the oldest pending verdict.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("output word with no verdict pending");
            end else begin
                bit want;
                want = verdicts_due.pop_front();
                if (out_if.probable_prime !== want)
                    report_mismatch($sformatf("probable_prime %b, want %b",
                                              out_if.probable_prime, want));
            end
        end
    end

    task automatic add_word(t_num cand, t_rounds rounds, bit drain = 1'b0);
        t_test_word w;
        w.candidate   = cand;
        w.rounds      = rounds;
        w.drain_first = drain;
        pending_words.push_back(w);
    endtask

    // Stimulus and end of run.
    initial begin
        int total;
        int sel;
        t_num c;
        // Directed: the small special values, round extremes, large values.
        add_word(31'd0, 8'd5);
        add_word(31'd1, 8'd255);
        add_word(31'd2, 8'd0);
        add_word(31'd2, 8'd255);
        add_word(31'd3, 8'd255);
        add_word(31'd3, 8'd0);
        add_word(31'd4, 8'd3);
        add_word(31'd9, 8'd0);
        add_word(31'd9, 8'd2);
        add_word(31'd15, 8'd1);
        add_word(31'd561, 8'd4);
        add_word(31'd1105, 8'd6);
        add_word(31'd97, 8'd10);
        add_word(31'd7, 8'd255);
        add_word(31'h7FFF_FFFF, 8'd3);
        add_word(31'h7FFF_FFFE, 8'd1);
        add_word(31'h7FFF_FFFD, 8'd2);
        add_word(31'd2147483629, 8'd2);
        add_word(31'd65537, 8'd5);
        add_word(31'd25, 8'd170, 1'b1);
        // Random: mostly odd values with few rounds, some small odd values with
        // any round count, some arbitrary words.
        for (int k = 0; k < 80; k++) begin
            sel = $urandom_range(99);
            if (sel < 55) begin
                c = t_num'($urandom()) | 31'd1;
                add_word(c, t_rounds'($urandom_range(4)), k == 50);
            end else if (sel < 80) begin
                c = t_num'($urandom_range(3, 1023)) | 31'd1;
                add_word(c, t_rounds'($urandom_range(255)));
            end else begin
                c = t_num'($urandom());
                add_word(c, t_rounds'($urandom()));
            end
        end
        total = pending_words.size();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (words_taken == total);
        wait (verdicts_due.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #1s;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
